FILE: rtl/core/v4m_pkg.sv
// Shared types and constants for the four-component vector math unit.
// Holds the transfer structs, action/status codes and the 32-bit saturator.
// No dependencies.
package v4m_pkg;

  localparam logic [3:0] ACT_ADD   = 4'd0;
  localparam logic [3:0] ACT_SUB   = 4'd1;
  localparam logic [3:0] ACT_SCALE = 4'd2;
  localparam logic [3:0] ACT_DOT3  = 4'd3;
  localparam logic [3:0] ACT_DOT4  = 4'd4;
  localparam logic [3:0] ACT_CROSS = 4'd5;
  localparam logic [3:0] ACT_LEN   = 4'd6;
  localparam logic [3:0] ACT_NORM  = 4'd7;
  localparam logic [3:0] ACT_EQUAL = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] scale_factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic signed [31:0] res_scalar;
    logic               is_equal;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [66:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > 67'sd2147483647) begin
      r.ovf = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      r.ovf = 1'b1;
      r.val = 32'sh80000000;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/v4m_lane.sv
// One component lane: registered products, sums and differences for a single vector element.
// Depends on nothing beyond the standard types.
module v4m_lane (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] b_next,
  input  logic signed [31:0] b_prev,
  input  logic signed [31:0] f,
  output logic signed [63:0] p_ab,
  output logic signed [63:0] p_af,
  output logic signed [63:0] p_aa,
  output logic signed [63:0] p_n1,
  output logic signed [63:0] p_n2,
  output logic signed [32:0] sum_ab,
  output logic signed [32:0] dif_ab
);

  always_ff @(posedge clk) begin
    p_ab   <= 64'(a) * 64'(b);
    p_af   <= 64'(a) * 64'(f);
    p_aa   <= 64'(a) * 64'(a);
    p_n1   <= 64'(a) * 64'(b_next);
    p_n2   <= 64'(a) * 64'(b_prev);
    sum_ab <= 33'(a) + 33'(b);
    dif_ab <= 33'(a) - 33'(b);
  end

endmodule

FILE: rtl/core/v4m_isqrt.sv
// Pipelined integer square root, one root bit per stage, 32 stages.
// Depends on nothing beyond the standard types.
module v4m_isqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] rad_r [32];
  logic [32:0] rem_r [32];
  logic [31:0] q_r   [32];

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [63:0] rad_p;
    logic [32:0] rem_p;
    logic [31:0] q_p;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    always_comb begin
      if (k == 0) begin
        rad_p = rad;
        rem_p = '0;
        q_p   = '0;
      end else begin
        rad_p = rad_r[k-1];
        rem_p = rem_r[k-1];
        q_p   = q_r[k-1];
      end
      rem_sh = {rem_p, rad_p[63-2*k -: 2]};
      trial  = {1'b0, q_p, 2'b01};
    end
    always_ff @(posedge clk) begin
      rad_r[k] <= rad_p;
      if (rem_sh >= trial) begin
        rem_r[k] <= 33'(rem_sh - trial);
        q_r[k]   <= {q_p[30:0], 1'b1};
      end else begin
        rem_r[k] <= rem_sh[32:0];
        q_r[k]   <= {q_p[30:0], 1'b0};
      end
    end
  end

  assign root = q_r[31];

endmodule

FILE: rtl/core/v4m_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing beyond the standard types.
module v4m_div #(
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic [DW-1:0] num,
  input  logic [31:0]   den,
  output logic [DW-1:0] quo
);

  logic [DW-1:0] num_r [DW];
  logic [31:0]   den_r [DW];
  logic [31:0]   rem_r [DW];
  logic [DW-1:0] q_r   [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] num_p;
    logic [31:0]   den_p;
    logic [31:0]   rem_p;
    logic [DW-1:0] q_p;
    logic [32:0]   rem_sh;
    always_comb begin
      if (k == 0) begin
        num_p = num;
        den_p = den;
        rem_p = '0;
        q_p   = '0;
      end else begin
        num_p = num_r[k-1];
        den_p = den_r[k-1];
        rem_p = rem_r[k-1];
        q_p   = q_r[k-1];
      end
      rem_sh = {rem_p, num_p[DW-1-k]};
    end
    always_ff @(posedge clk) begin
      num_r[k] <= num_p;
      den_r[k] <= den_p;
      if (rem_sh >= {1'b0, den_p}) begin
        rem_r[k] <= 32'(rem_sh - {1'b0, den_p});
        q_r[k]   <= {q_p[DW-2:0], 1'b1};
      end else begin
        rem_r[k] <= rem_sh[31:0];
        q_r[k]   <= {q_p[DW-2:0], 1'b0};
      end
    end
  end

  assign quo = q_r[DW-1];

endmodule

FILE: rtl/core/vector4_math_unit.sv
// Four-component Q-format vector math unit, fully pipelined.
// Uses v4m_pkg, v4m_lane, v4m_isqrt and v4m_div.
//
// Usage:
//   Drive in_item and raise start; the item transfers on any edge where
//   start is high and busy is low. busy is always low: the pipeline takes
//   one item every cycle, back to back.
//   Every item gives exactly one result on out_item, marked by out_valid
//   for one cycle. Every action runs through the same pipeline, so
//   results leave in order at one per cycle.
//   Latency is set by the 32-stage square root followed by the
//   (32 + FRAC_BITS)-stage divider used for normalize.
//   The receiver cannot stall; results are not held.
//   Synchronous reset (rst_n low) clears all valid bits; items in flight
//   are dropped. No clearing pass is needed.
module vector4_math_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  v4m_pkg::in_t   in_item,
  output logic           out_valid,
  output v4m_pkg::out_t  out_item
);
  import v4m_pkg::*;

  localparam int DW     = 32 + FRAC_BITS;
  localparam int SQ_LAT = 32;
  localparam int LAT    = 3 + SQ_LAT + DW;

  typedef struct packed {
    logic [3:0]         action;
    out_t               res;
    logic [2:0]         neg;
    logic [31:0]        mag_x;
    logic [31:0]        mag_y;
    logic [31:0]        mag_z;
    logic signed [31:0] a_w;
    logic               len_zero;
  } trk_t;

  logic  v1_r, v2_r, v3_r;
  in_t   in1_r, in2_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    in1_r <= in_item;
    in2_r <= in1_r;
  end

  // lanes
  logic signed [31:0] a_v [4];
  logic signed [31:0] b_v [4];
  logic signed [63:0] p_ab [4];
  logic signed [63:0] p_af [4];
  logic signed [63:0] p_aa [4];
  logic signed [32:0] s_ab [4];
  logic signed [32:0] d_ab [4];
  logic signed [63:0] p_n1 [3];
  logic signed [63:0] p_n2 [3];

  assign a_v[0] = in1_r.a_x;
  assign a_v[1] = in1_r.a_y;
  assign a_v[2] = in1_r.a_z;
  assign a_v[3] = in1_r.a_w;
  assign b_v[0] = in1_r.b_x;
  assign b_v[1] = in1_r.b_y;
  assign b_v[2] = in1_r.b_z;
  assign b_v[3] = in1_r.b_w;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v4m_lane u_lane (
      .clk    (clk),
      .a      (a_v[i]),
      .b      (b_v[i]),
      .b_next (b_v[(i+1)%3]),
      .b_prev (b_v[(i+2)%3]),
      .f      (in1_r.scale_factor),
      .p_ab   (p_ab[i]),
      .p_af   (p_af[i]),
      .p_aa   (p_aa[i]),
      .p_n1   (p_n1[i]),
      .p_n2   (p_n2[i]),
      .sum_ab (s_ab[i]),
      .dif_ab (d_ab[i])
    );
  end

  v4m_lane u_lane_w (
    .clk    (clk),
    .a      (a_v[3]),
    .b      (b_v[3]),
    .b_next ('0),
    .b_prev ('0),
    .f      (in1_r.scale_factor),
    .p_ab   (p_ab[3]),
    .p_af   (p_af[3]),
    .p_aa   (p_aa[3]),
    .p_n1   (),
    .p_n2   (),
    .sum_ab (s_ab[3]),
    .dif_ab (d_ab[3])
  );

  // merge: direct results
  trk_t        trk_nxt, trk3_r;
  logic [63:0] sumsq_nxt, sumsq3_r;

  always_comb begin
    logic signed [66:0] dot;
    logic signed [66:0] cr;
    sat_t               st;
    logic               ov;
    logic signed [31:0] v [4];
    logic signed [31:0] sc;
    logic               eq;
    ov  = 1'b0;
    sc  = '0;
    eq  = 1'b0;
    dot = 67'(p_ab[0]) + 67'(p_ab[1]) + 67'(p_ab[2]);
    cr  = '0;
    st  = '0;
    for (int i = 0; i < 4; i++) v[i] = '0;
    case (in2_r.action)
      ACT_ADD: begin
        for (int i = 0; i < 4; i++) begin
          st = sat32(67'(s_ab[i]));
          v[i] = st.val;
          ov = ov | st.ovf;
        end
      end
      ACT_SUB: begin
        for (int i = 0; i < 4; i++) begin
          st = sat32(67'(d_ab[i]));
          v[i] = st.val;
          ov = ov | st.ovf;
        end
      end
      ACT_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          st = sat32(67'(p_af[i]) >>> FRAC_BITS);
          v[i] = st.val;
          ov = ov | st.ovf;
        end
      end
      ACT_DOT3, ACT_DOT4: begin
        if (in2_r.action == ACT_DOT4) dot = dot + 67'(p_ab[3]);
        st = sat32(dot >>> FRAC_BITS);
        sc = st.val;
        ov = st.ovf;
      end
      ACT_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          cr = 67'(p_n1[(i+1)%3]) - 67'(p_n2[(i+2)%3]);
          st = sat32(cr >>> FRAC_BITS);
          v[i] = st.val;
          ov = ov | st.ovf;
        end
      end
      ACT_EQUAL: begin
        eq = (in2_r.a_x == in2_r.b_x) && (in2_r.a_y == in2_r.b_y) &&
             (in2_r.a_z == in2_r.b_z) && (in2_r.a_w == in2_r.b_w);
      end
      default: ;
    endcase
    trk_nxt.action         = in2_r.action;
    trk_nxt.res.res_x      = v[0];
    trk_nxt.res.res_y      = v[1];
    trk_nxt.res.res_z      = v[2];
    trk_nxt.res.res_w      = v[3];
    trk_nxt.res.res_scalar = sc;
    trk_nxt.res.is_equal   = eq;
    trk_nxt.res.status     = ov ? ST_SAT : ST_OK;
    trk_nxt.neg            = {in2_r.a_z[31], in2_r.a_y[31], in2_r.a_x[31]};
    trk_nxt.mag_x          = in2_r.a_x[31] ? 32'(-in2_r.a_x) : 32'(in2_r.a_x);
    trk_nxt.mag_y          = in2_r.a_y[31] ? 32'(-in2_r.a_y) : 32'(in2_r.a_y);
    trk_nxt.mag_z          = in2_r.a_z[31] ? 32'(-in2_r.a_z) : 32'(in2_r.a_z);
    trk_nxt.a_w            = in2_r.a_w;
    trk_nxt.len_zero       = 1'b0;
    sumsq_nxt = 64'(p_aa[0]) + 64'(p_aa[1]) + 64'(p_aa[2]);
  end

  always_ff @(posedge clk) begin
    trk3_r   <= trk_nxt;
    sumsq3_r <= sumsq_nxt;
  end

  // square root and its delay line
  logic [31:0] root;
  trk_t        chain_a_r [SQ_LAT];
  logic [SQ_LAT-1:0] va_r;

  v4m_isqrt u_isqrt (
    .clk  (clk),
    .rad  (sumsq3_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    chain_a_r[0] <= trk3_r;
    for (int k = 1; k < SQ_LAT; k++) chain_a_r[k] <= chain_a_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= '0;
    else        va_r <= {va_r[SQ_LAT-2:0], v3_r};
  end

  trk_t trk_m;
  always_comb begin
    trk_m = chain_a_r[SQ_LAT-1];
    trk_m.len_zero = (root == '0);
    if (trk_m.action == ACT_LEN) begin
      if (root[31]) begin
        trk_m.res.res_scalar = 32'sh7fffffff;
        trk_m.res.status     = ST_SAT;
      end else begin
        trk_m.res.res_scalar = root;
        trk_m.res.status     = ST_OK;
      end
    end
  end

  // normalize lanes
  logic [DW-1:0] quo [3];
  logic [31:0]   mag_m [3];
  assign mag_m[0] = trk_m.mag_x;
  assign mag_m[1] = trk_m.mag_y;
  assign mag_m[2] = trk_m.mag_z;

  for (genvar i = 0; i < 3; i++) begin : g_div
    v4m_div #(.DW(DW)) u_div (
      .clk (clk),
      .num ({mag_m[i], {FRAC_BITS{1'b0}}}),
      .den (root),
      .quo (quo[i])
    );
  end

  trk_t          chain_b_r [DW];
  logic [DW-1:0] vb_r;

  always_ff @(posedge clk) begin
    chain_b_r[0] <= trk_m;
    for (int k = 1; k < DW; k++) chain_b_r[k] <= chain_b_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= '0;
    else        vb_r <= {vb_r[DW-2:0], va_r[SQ_LAT-1]};
  end

  // output stage
  trk_t tail;
  out_t out_nxt, out_item_r;
  logic out_valid_r;

  assign tail = chain_b_r[DW-1];

  always_comb begin
    sat_t               st;
    logic               ov;
    logic signed [66:0] q;
    logic signed [31:0] v [3];
    ov = 1'b0;
    st = '0;
    q  = '0;
    for (int i = 0; i < 3; i++) begin
      q = tail.neg[i] ? -67'(quo[i]) : 67'(quo[i]);
      st = sat32(q);
      v[i] = st.val;
      ov = ov | st.ovf;
    end
    out_nxt = tail.res;
    if (tail.action == ACT_NORM) begin
      if (tail.len_zero) begin
        out_nxt        = '0;
        out_nxt.status = ST_ZERO;
      end else begin
        out_nxt.res_x      = v[0];
        out_nxt.res_y      = v[1];
        out_nxt.res_z      = v[2];
        out_nxt.res_w      = tail.a_w;
        out_nxt.res_scalar = '0;
        out_nxt.is_equal   = 1'b0;
        out_nxt.status     = ov ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vb_r[DW-1];
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT + 1))
    else $error("result without a matching input transfer");

  a_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_ZERO |->
      out_item.res_x == '0 && out_item.res_y == '0 && out_item.res_z == '0 &&
      out_item.res_w == '0 && out_item.res_scalar == '0)
    else $error("zero-length normalize left nonzero fields");

  a_equal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_equal |->
      out_item.status == ST_OK && out_item.res_scalar == '0)
    else $error("equal result carries other fields");

endmodule
